// ===== src/shirr_pkg.sv =====
`timescale 1ns / 1ps
package shirr_pkg;

  // Coefficient store geometry: nine harmonics times three color channels.
  localparam int unsigned NUM_WORDS = 27;

  // Transaction operation codes.
  localparam logic OP_SHADE = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  // Register stages in the normalization unit, from the accepting edge to its output.
  localparam int unsigned NORM_DEPTH = 43;

  // Polynomial constants in Q0.16, held signed with headroom so products stay signed.
  localparam logic signed [17:0] K_C1  = 18'sd28118;
  localparam logic signed [17:0] K_2C1 = 18'sd56236;
  localparam logic signed [17:0] K_2C2 = 18'sd67064;
  localparam logic signed [17:0] K_C3  = 18'sd48701;
  localparam logic signed [17:0] K_C4  = 18'sd58080;
  localparam logic signed [17:0] K_C5  = 18'sd16234;

  typedef logic signed [15:0] word_t;

  // One input transaction.
  typedef struct packed {
    logic              operation;
    logic [4:0]        coeff_index;
    logic signed [15:0] coeff_value;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [15:0] irradiance_red;
    logic [15:0] irradiance_green;
    logic [15:0] irradiance_blue;
  } result_t;

  // Unit normal in signed Q1.14.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } unit_t;

  // Lighting preset loaded at reset, Q3.12, word k*3+c is harmonic k of channel c.
  localparam word_t PRESET [NUM_WORDS] = '{
    16'sd1475, 16'sd1065, 16'sd942,
    16'sd737,  16'sd573,  16'sd532,
    -16'sd82,  -16'sd41,  16'sd0,
    16'sd123,  16'sd82,   16'sd41,
    16'sd82,   16'sd41,   16'sd0,
    -16'sd205, -16'sd123, -16'sd41,
    -16'sd369, -16'sd328, -16'sd287,
    16'sd410,  16'sd0,    16'sd0,
    -16'sd328, -16'sd246, 16'sd0
  };

endpackage

// ===== src/shirr_norm.sv =====
`timescale 1ns / 1ps
module shirr_norm (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  shirr_pkg::cmd_t  in_item,
  output logic             out_valid,
  output shirr_pkg::cmd_t  out_item,
  output shirr_pkg::unit_t out_unit
);
  import shirr_pkg::*;

  localparam int ROOT_BITS = 24;
  localparam int QUOT_BITS = 15;
  localparam int REM_W     = 50;
  localparam int DIV_W     = 40;

  // Pick one normal component by lane number.
  function automatic logic signed [15:0] lane_val(cmd_t it, int lane);
    logic signed [15:0] v;
    case (lane)
      0:       v = it.normal_x;
      1:       v = it.normal_y;
      default: v = it.normal_z;
    endcase
    return v;
  endfunction

  // Magnitude of a signed component; the most negative value maps to 32768.
  function automatic logic [15:0] mag16(logic signed [15:0] v);
    logic [15:0] m;
    m = v[15] ? 16'(-v) : 16'(v);
    return m;
  endfunction

  // Squares of the raw components.
  logic               sq_valid;
  cmd_t               sq_item;
  logic signed [31:0] sq_x;
  logic signed [31:0] sq_y;
  logic signed [31:0] sq_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sq_item <= in_item;
    sq_x    <= in_item.normal_x * in_item.normal_x;
    sq_y    <= in_item.normal_y * in_item.normal_y;
    sq_z    <= in_item.normal_z * in_item.normal_z;
  end

  // Square root of the squared length scaled by 2^16, one result bit per stage.
  logic                 rt_valid [ROOT_BITS+1];
  cmd_t                 rt_item  [ROOT_BITS+1];
  logic                 rt_zero  [ROOT_BITS+1];
  logic [REM_W-1:0]     rt_rem   [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] rt_root  [ROOT_BITS+1];
  logic [31:0]          len_sq;

  assign len_sq = 32'(sq_x) + 32'(sq_y) + 32'(sq_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_valid[0] <= 1'b0;
    end else begin
      rt_valid[0] <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    rt_item[0] <= sq_item;
    rt_zero[0] <= (len_sq == 32'd0);
    rt_rem[0]  <= {2'b00, len_sq, 16'h0000};
    rt_root[0] <= '0;
  end

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_root
    localparam int B = ROOT_BITS - 1 - i;
    logic [REM_W-1:0] trial;

    assign trial = ({{(REM_W-ROOT_BITS){1'b0}}, rt_root[i]} << (B + 1))
                 + ({{(REM_W-1){1'b0}}, 1'b1} << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_valid[i+1] <= 1'b0;
      end else begin
        rt_valid[i+1] <= rt_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      rt_item[i+1] <= rt_item[i];
      rt_zero[i+1] <= rt_zero[i];
      if (rt_rem[i] >= trial) begin
        rt_rem[i+1]  <= rt_rem[i] - trial;
        rt_root[i+1] <= rt_root[i] | ({{(ROOT_BITS-1){1'b0}}, 1'b1} << B);
      end else begin
        rt_rem[i+1]  <= rt_rem[i];
        rt_root[i+1] <= rt_root[i];
      end
    end
  end

  // Rounded division of each magnitude by the root, one quotient bit per stage.
  logic                 dv_valid [QUOT_BITS+1];
  cmd_t                 dv_item  [QUOT_BITS+1];
  logic                 dv_zero  [QUOT_BITS+1];
  logic [ROOT_BITS-1:0] dv_r     [QUOT_BITS+1];
  logic [DIV_W-1:0]     dv_rem   [QUOT_BITS+1][3];
  logic [QUOT_BITS-1:0] dv_q     [QUOT_BITS+1][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else begin
      dv_valid[0] <= rt_valid[ROOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    dv_item[0] <= rt_item[ROOT_BITS];
    dv_zero[0] <= rt_zero[ROOT_BITS];
    dv_r[0]    <= rt_root[ROOT_BITS];
    for (int c = 0; c < 3; c++) begin
      dv_rem[0][c] <= {2'b00, mag16(lane_val(rt_item[ROOT_BITS], c)), 22'd0}
                    + {17'd0, rt_root[ROOT_BITS][ROOT_BITS-1:1]};
      dv_q[0][c]   <= '0;
    end
  end

  for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
    localparam int B = QUOT_BITS - 1 - j;
    logic [DIV_W-1:0] den;

    assign den = {{(DIV_W-ROOT_BITS){1'b0}}, dv_r[j]} << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j+1] <= 1'b0;
      end else begin
        dv_valid[j+1] <= dv_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      dv_item[j+1] <= dv_item[j];
      dv_zero[j+1] <= dv_zero[j];
      dv_r[j+1]    <= dv_r[j];
      for (int c = 0; c < 3; c++) begin
        if (dv_rem[j][c] >= den) begin
          dv_rem[j+1][c] <= dv_rem[j][c] - den;
          dv_q[j+1][c]   <= dv_q[j][c] | ({{(QUOT_BITS-1){1'b0}}, 1'b1} << B);
        end else begin
          dv_rem[j+1][c] <= dv_rem[j][c];
          dv_q[j+1][c]   <= dv_q[j][c];
        end
      end
    end
  end

  // Clamp to unit magnitude, restore the sign and force a zero normal to zero.
  logic signed [15:0] comp [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [QUOT_BITS-1:0] q;
      q = dv_q[QUOT_BITS][c];
      if (q > 15'd16384) begin
        q = 15'd16384;
      end
      if (dv_zero[QUOT_BITS]) begin
        comp[c] = '0;
      end else if (lane_val(dv_item[QUOT_BITS], c) < 0) begin
        comp[c] = -$signed({1'b0, q});
      end else begin
        comp[c] = $signed({1'b0, q});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_valid[QUOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    out_item   <= dv_item[QUOT_BITS];
    out_unit.x <= comp[0];
    out_unit.y <= comp[1];
    out_unit.z <= comp[2];
  end

  // A normalized component never exceeds unit magnitude.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_unit.x <= 16384 && out_unit.x >= -16384 &&
                   out_unit.y <= 16384 && out_unit.y >= -16384 &&
                   out_unit.z <= 16384 && out_unit.z >= -16384))
    else $error("normalized component out of range");

  // A zero normal must come out as a zero unit vector.
  a_zero_normal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.normal_x == 0 && out_item.normal_y == 0 &&
     out_item.normal_z == 0) |-> (out_unit == '0))
    else $error("zero normal did not give a zero unit vector");

  // Every transaction leaves the unit after the fixed pipeline depth.
  a_fixed_depth: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##NORM_DEPTH out_valid)
    else $error("transaction lost in the normalization unit");

endmodule

// ===== src/sh_irradiance_shader.sv =====
`timescale 1ns / 1ps
// Second-order spherical-harmonic irradiance shader. A transaction is taken on every clock
// at which start is high; busy is always low, so a new normal or coefficient load can enter
// each cycle. A shade transaction returns red, green and blue irradiance in unsigned Q4.12,
// marked by done for one cycle; the receiver cannot stall, so the result must be captured in
// that cycle. The shade passes through the normalization unit, whose 24-stage square root
// and 15-stage divider each resolve one bit per stage, and then the polynomial pipeline. A
// load transaction returns nothing and updates the coefficient word when it passes the
// coefficient stage, so it affects exactly the shades accepted after it. Reset restores the
// built-in lighting preset.
module sh_irradiance_shader (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  shirr_pkg::cmd_t    item,
  output logic               busy,
  output logic               done,
  output shirr_pkg::result_t result
);
  import shirr_pkg::*;

  localparam int LATENCY = NORM_DEPTH + 8;
  localparam int ACC_W   = 56;

  // Round a Q2.28 product half away from zero to Q1.14.
  function automatic logic signed [15:0] rnd14(logic signed [31:0] p);
    logic [31:0] mag;
    logic [31:0] m;
    mag = p[31] ? 32'(-p) : 32'(p);
    m   = (mag + 32'd8192) >> 14;
    return p[31] ? -$signed(m[15:0]) : $signed(m[15:0]);
  endfunction

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Normalization unit.
  logic  n_valid;
  cmd_t  n_item;
  unit_t n_unit;

  shirr_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .in_item  (item),
    .out_valid(n_valid),
    .out_item (n_item),
    .out_unit (n_unit)
  );

  // Stage 1: quadratic products of the unit normal.
  logic               q1_valid;
  cmd_t               q1_item;
  unit_t              q1_unit;
  logic signed [31:0] q1_p [6];

  // Stage 2: products rounded to Q1.14.
  logic               q2_valid;
  cmd_t               q2_item;
  unit_t              q2_unit;
  logic signed [15:0] q2_t [6];

  // Stage 3: coefficient products per channel.
  logic               q3_valid;
  cmd_t               q3_item;
  logic signed [33:0] q3_t  [3][8];
  logic signed [33:0] q3_c0 [3];
  logic signed [33:0] q3_c6 [3];

  // Stage 4: grouped sums per channel.
  logic               q4_valid;
  cmd_t               q4_item;
  logic signed [35:0] q4_s [3][5];

  // Stage 5: scaled by the polynomial constants.
  logic               q5_valid;
  cmd_t               q5_item;
  logic signed [ACC_W-1:0] q5_p [3][5];

  // Stage 6 and 7: accumulation.
  logic               q6_valid;
  cmd_t               q6_item;
  logic signed [ACC_W-1:0] q6_a [3][2];
  logic               q7_valid;
  cmd_t               q7_item;
  logic signed [ACC_W-1:0] q7_acc [3];

  // Coefficient store.
  word_t coeff [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_valid <= 1'b0;
      q2_valid <= 1'b0;
      q3_valid <= 1'b0;
      q4_valid <= 1'b0;
      q5_valid <= 1'b0;
      q6_valid <= 1'b0;
      q7_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      q1_valid <= n_valid;
      q2_valid <= q1_valid;
      q3_valid <= q2_valid;
      q4_valid <= q3_valid;
      q5_valid <= q4_valid;
      q6_valid <= q5_valid;
      q7_valid <= q6_valid;
      done     <= q7_valid && (q7_item.operation == OP_SHADE);
    end
  end

  // Quadratic products.
  always_ff @(posedge clk) begin
    q1_item <= n_item;
    q1_unit <= n_unit;
    q1_p[0] <= n_unit.x * n_unit.x;
    q1_p[1] <= n_unit.y * n_unit.y;
    q1_p[2] <= n_unit.z * n_unit.z;
    q1_p[3] <= n_unit.x * n_unit.y;
    q1_p[4] <= n_unit.x * n_unit.z;
    q1_p[5] <= n_unit.y * n_unit.z;
  end

  // Rounding of the products.
  always_ff @(posedge clk) begin
    q2_item <= q1_item;
    q2_unit <= q1_unit;
    for (int k = 0; k < 6; k++) begin
      q2_t[k] <= rnd14(q1_p[k]);
    end
  end

  // Loads update the store in transaction order as they pass this stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        coeff[i] <= PRESET[i];
      end
    end else if (q2_valid && q2_item.operation == OP_LOAD &&
                 q2_item.coeff_index < 5'(NUM_WORDS)) begin
      coeff[q2_item.coeff_index] <= q2_item.coeff_value;
    end
  end

  // Coefficient times term products for each channel.
  logic signed [16:0] dxy;
  assign dxy = {q2_t[0][15], q2_t[0]} - {q2_t[1][15], q2_t[1]};

  always_ff @(posedge clk) begin
    q3_item <= q2_item;
    for (int ch = 0; ch < 3; ch++) begin
      q3_t[ch][0] <= coeff[8*3+ch] * dxy;
      q3_t[ch][1] <= coeff[6*3+ch] * q2_t[2];
      q3_t[ch][2] <= coeff[4*3+ch] * q2_t[3];
      q3_t[ch][3] <= coeff[7*3+ch] * q2_t[4];
      q3_t[ch][4] <= coeff[5*3+ch] * q2_t[5];
      q3_t[ch][5] <= coeff[3*3+ch] * q2_unit.x;
      q3_t[ch][6] <= coeff[1*3+ch] * q2_unit.y;
      q3_t[ch][7] <= coeff[2*3+ch] * q2_unit.z;
      q3_c0[ch]   <= K_C4 * coeff[0*3+ch];
      q3_c6[ch]   <= K_C5 * coeff[6*3+ch];
    end
  end

  // Group the terms that share a constant.
  always_ff @(posedge clk) begin
    q4_item <= q3_item;
    for (int ch = 0; ch < 3; ch++) begin
      q4_s[ch][0] <= 36'(q3_t[ch][0]);
      q4_s[ch][1] <= 36'(q3_t[ch][1]);
      q4_s[ch][2] <= 36'(q3_t[ch][2]) + 36'(q3_t[ch][3]) + 36'(q3_t[ch][4]);
      q4_s[ch][3] <= 36'(q3_t[ch][5]) + 36'(q3_t[ch][6]) + 36'(q3_t[ch][7]);
      q4_s[ch][4] <= 36'(q3_c0[ch]) - 36'(q3_c6[ch]);
    end
  end

  // Apply the constants; the constant term is aligned to the common 2^-42 scale.
  always_ff @(posedge clk) begin
    q5_item <= q4_item;
    for (int ch = 0; ch < 3; ch++) begin
      q5_p[ch][0] <= K_C1 * q4_s[ch][0];
      q5_p[ch][1] <= K_C3 * q4_s[ch][1];
      q5_p[ch][2] <= K_2C1 * q4_s[ch][2];
      q5_p[ch][3] <= K_2C2 * q4_s[ch][3];
      q5_p[ch][4] <= ACC_W'(q4_s[ch][4]) <<< 14;
    end
  end

  // Two-level sum of the five terms.
  always_ff @(posedge clk) begin
    q6_item <= q5_item;
    q7_item <= q6_item;
    for (int ch = 0; ch < 3; ch++) begin
      q6_a[ch][0] <= q5_p[ch][0] + q5_p[ch][1] + q5_p[ch][4];
      q6_a[ch][1] <= q5_p[ch][2] + q5_p[ch][3];
      q7_acc[ch]  <= q6_a[ch][0] + q6_a[ch][1];
    end
  end

  // Round to Q4.12, clamp at zero and saturate at the top.
  logic [15:0] chan [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic [ACC_W-1:0] rounded;
      rounded = (q7_acc[ch] + ACC_W'(64'd536870912)) >>> 30;
      if (q7_acc[ch] < 0) begin
        chan[ch] = 16'd0;
      end else if (rounded > ACC_W'(64'd65535)) begin
        chan[ch] = 16'hFFFF;
      end else begin
        chan[ch] = rounded[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    result.irradiance_red   <= chan[0];
    result.irradiance_green <= chan[1];
    result.irradiance_blue  <= chan[2];
  end

  // Every shade transaction yields a result after the fixed latency.
  a_shade_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.operation == OP_SHADE) |-> ##LATENCY done)
    else $error("shade transaction produced no result");

  // A load transaction never produces a result.
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.operation == OP_LOAD) |-> ##LATENCY !done)
    else $error("load transaction produced a result");

  // No result appears without a transaction behind it.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !start |-> ##LATENCY !done)
    else $error("result without a transaction");

endmodule
